[hw/rtl/gsppm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsppm_pkg
// shared types, register map, codes, constants and helper functions of the gas sensor
// ppm conversion pipeline
// ----------------------------------------------------------------------------
package gsppm_pkg;

   localparam int RAW_W     = 12;
   localparam int LOG_STEPS = 16;
   localparam int DIV_BITS  = 34;
   localparam int EXP_STEPS = 16;

   localparam int LOG10_2_Q16 = 19728;
   localparam int LOG2_10_Q16 = 217706;

   // register map
   localparam logic [2:0] REG_RO          = 3'd0;
   localparam logic [2:0] REG_LPG_X       = 3'd1;
   localparam logic [2:0] REG_LPG_Y       = 3'd2;
   localparam logic [2:0] REG_LPG_SLOPE   = 3'd3;
   localparam logic [2:0] REG_SMOKE_X     = 3'd4;
   localparam logic [2:0] REG_SMOKE_Y     = 3'd5;
   localparam logic [2:0] REG_SMOKE_SLOPE = 3'd6;

   localparam logic [15:0] RO_RESET          = 16'd2560;
   localparam logic [15:0] LPG_X_RESET       = 16'd9421;
   localparam logic [15:0] LPG_Y_RESET       = 16'd819;
   localparam logic [15:0] LPG_SLOPE_RESET   = 16'hF8CD;
   localparam logic [15:0] SMOKE_X_RESET     = 16'd9421;
   localparam logic [15:0] SMOKE_Y_RESET     = 16'd2171;
   localparam logic [15:0] SMOKE_SLOPE_RESET = 16'hF91F;

   // gas selector codes
   localparam logic [1:0] OP_PASS_LO = 2'd0;
   localparam logic [1:0] OP_LPG     = 2'd1;
   localparam logic [1:0] OP_SMOKE   = 2'd2;
   localparam logic [1:0] OP_PASS_HI = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   typedef enum logic [2:0] {
      KIND_CURVE,
      KIND_PASS,
      KIND_ZERO,
      KIND_SAT,
      KIND_TINY
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [RAW_W-1:0] raw;
   } ctl_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] slope;
   } curve_type;

   typedef struct packed {
      logic [4:0]  pn;
      logic [4:0]  pd;
      logic [31:0] mn;
      logic [31:0] md;
      logic [15:0] fn;
      logic [15:0] fd;
   } lg_type;

   typedef struct packed {
      logic [15:0]         rem;
      logic [DIV_BITS-1:0] dvd;
      logic [15:0]         dsr;
      logic                neg;
   } dv_type;

   typedef struct packed {
      logic [30:0] acc;
      logic [15:0] f;
      logic [4:0]  sh;
   } ex_type;

   // integer square root, used only at elaboration
   function automatic logic [63:0] gsppm_isqrt(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] b;
      v   = v_in;
      res = '0;
      b   = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // 2^(1/2^k) in q30 by repeated truncating square roots
   function automatic logic [30:0] gsppm_root_q30(input int k);
      logic [63:0] root;
      root = 64'h8000_0000;
      for (int j = 1; j <= k; j++) begin
         root = gsppm_isqrt(root << 30);
      end
      return root[30:0];
   endfunction

   // index of the highest set bit, zero for zero
   function automatic logic [4:0] gsppm_msb(input logic [31:0] v);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            p = 5'(i);
         end
      end
      return p;
   endfunction

endpackage

[hw/rtl/gsppm_log_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsppm_log_cell
// one squaring step of the log2 fraction, for numerator and denominator
// ----------------------------------------------------------------------------
module gsppm_log_cell import gsppm_pkg::*; #(
   parameter int BIT = 15
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  ctl_type   in_ctl,
   input  curve_type in_cur,
   input  lg_type    in_lg,
   output logic      out_valid,
   output ctl_type   out_ctl,
   output curve_type out_cur,
   output lg_type    out_lg
);

   logic      valid_ff;
   ctl_type   ctl_ff;
   curve_type cur_ff;
   lg_type    lg_ff;
   lg_type    lg_in;
   logic [63:0] sq_n;
   logic [63:0] sq_d;

   always_comb begin
      lg_in = in_lg;
      sq_n  = 64'(in_lg.mn) * 64'(in_lg.mn);
      sq_d  = 64'(in_lg.md) * 64'(in_lg.md);
      // renormalize when the square reaches two
      if (sq_n[63]) begin
         lg_in.mn     = sq_n[63:32];
         lg_in.fn[BIT] = 1'b1;
      end else begin
         lg_in.mn = sq_n[62:31];
      end
      if (sq_d[63]) begin
         lg_in.md     = sq_d[63:32];
         lg_in.fd[BIT] = 1'b1;
      end else begin
         lg_in.md = sq_d[62:31];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff <= in_ctl;
         cur_ff <= in_cur;
         lg_ff  <= lg_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_cur   = cur_ff;
   assign out_lg    = lg_ff;

endmodule

[hw/rtl/gsppm_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsppm_div_cell
// one restoring step of the division by the curve slope
// ----------------------------------------------------------------------------
module gsppm_div_cell import gsppm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  ctl_type     in_ctl,
   input  logic [15:0] in_x,
   input  dv_type      in_dv,
   output logic        out_valid,
   output ctl_type     out_ctl,
   output logic [15:0] out_x,
   output dv_type      out_dv
);

   logic        valid_ff;
   ctl_type     ctl_ff;
   logic [15:0] x_ff;
   dv_type      dv_ff;
   dv_type      dv_in;
   logic [16:0] r2;
   logic [16:0] diff;
   logic        ge;

   always_comb begin
      dv_in = in_dv;
      r2    = {in_dv.rem, in_dv.dvd[DIV_BITS-1]};
      diff  = r2 - {1'b0, in_dv.dsr};
      ge    = (r2 >= {1'b0, in_dv.dsr});
      dv_in.rem = ge ? diff[15:0] : r2[15:0];
      dv_in.dvd = {in_dv.dvd[DIV_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff <= in_ctl;
         x_ff   <= in_x;
         dv_ff  <= dv_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_x     = x_ff;
   assign out_dv    = dv_ff;

endmodule

[hw/rtl/gsppm_exp_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsppm_exp_cell
// one step of the exp2 fraction: multiply by a root of two when its bit is set
// ----------------------------------------------------------------------------
module gsppm_exp_cell import gsppm_pkg::*; #(
   parameter int STEP = 1
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    in_valid,
   input  ctl_type in_ctl,
   input  ex_type  in_ex,
   output logic    out_valid,
   output ctl_type out_ctl,
   output ex_type  out_ex
);

   localparam logic [30:0] ROOT = gsppm_root_q30(STEP);

   logic        valid_ff;
   ctl_type     ctl_ff;
   ex_type      ex_ff;
   ex_type      ex_in;
   logic [61:0] prod;

   always_comb begin
      ex_in = in_ex;
      prod  = 62'(in_ex.acc) * 62'(ROOT);
      if (in_ex.f[EXP_STEPS-STEP]) begin
         ex_in.acc = prod[60:30];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff <= in_ctl;
         ex_ff  <= ex_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_ex    = ex_ff;

endmodule

[hw/rtl/gas_sensor_ppm_conversion_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_sensor_ppm_conversion_unit
// converts an adc sample of the gas sensor divider into ppm on a log-log curve
// ----------------------------------------------------------------------------
// One request per clock is taken, and every request gives one result, in
// order. The pipeline is made of three chains of cells: 16 squaring cells
// that find the log2 fractions, 34 restoring cells that divide by the
// curve slope one quotient bit each, and 16 multiply cells that build the
// exp2 fraction; nine single stages do the rest. The whole pipeline holds
// while a result waits at the output and rsp_stall is high; req_stall is then
// raised. Configuration writes are always taken (csr_ready is tied high) and
// must only be made while no request is in flight. Pass-through selectors
// return the sample, a zero sample on a curve gives status one, and results
// of 2^32 or more in q24.8, a zero Ro or a zero slope give all ones with status two.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_conversion_unit import gsppm_pkg::*; #(
   parameter int ADC_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [RAW_W-1:0] req_raw_sample,
   input  logic [1:0]       req_op,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [31:0]      rsp_value,
   output logic [1:0]       rsp_status,
   // register write channel
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   localparam logic [31:0] MASK32 = (32'd1 << ADC_BITS) - 32'd1;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   logic [15:0] ro_ff;
   logic [15:0] lpg_x_ff;
   logic [15:0] lpg_y_ff;
   logic [15:0] lpg_slope_ff;
   logic [15:0] smoke_x_ff;
   logic [15:0] smoke_y_ff;
   logic [15:0] smoke_slope_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ro_ff          <= RO_RESET;
         lpg_x_ff       <= LPG_X_RESET;
         lpg_y_ff       <= LPG_Y_RESET;
         lpg_slope_ff   <= LPG_SLOPE_RESET;
         smoke_x_ff     <= SMOKE_X_RESET;
         smoke_y_ff     <= SMOKE_Y_RESET;
         smoke_slope_ff <= SMOKE_SLOPE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RO:          ro_ff          <= csr_wdata;
            REG_LPG_X:       lpg_x_ff       <= csr_wdata;
            REG_LPG_Y:       lpg_y_ff       <= csr_wdata;
            REG_LPG_SLOPE:   lpg_slope_ff   <= csr_wdata;
            REG_SMOKE_X:     smoke_x_ff     <= csr_wdata;
            REG_SMOKE_Y:     smoke_y_ff     <= csr_wdata;
            REG_SMOKE_SLOPE: smoke_slope_ff <= csr_wdata;
            default: ;  // writes beyond the map are dropped
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // pipeline enable: everything moves unless the output is held
   // ------------------------------------------------------------------------
   logic rsp_valid_ff;
   logic en;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // ------------------------------------------------------------------------
   // stage 0: mask the sample, pick the curve, form numerator and denominator
   // ------------------------------------------------------------------------
   logic [RAW_W-1:0]  raw;
   logic [ADC_BITS:0] fs_minus;
   logic [31:0]       nn;
   logic [31:0]       dd;
   ctl_type           ctl0;
   curve_type         cur0;

   always_comb begin
      raw      = req_raw_sample & MASK32[RAW_W-1:0];
      fs_minus = {1'b1, {ADC_BITS{1'b0}}} - (ADC_BITS + 1)'(raw);
      nn       = (32'(fs_minus) * 32'd10) << 8;   // 10 * (fs - raw) in q8
      dd       = 32'(raw) * 32'(ro_ff);
      if (req_op == OP_LPG) begin
         cur0.x     = lpg_x_ff;
         cur0.y     = lpg_y_ff;
         cur0.slope = lpg_slope_ff;
      end else begin
         cur0.x     = smoke_x_ff;
         cur0.y     = smoke_y_ff;
         cur0.slope = smoke_slope_ff;
      end
      ctl0.raw = raw;
      if (req_op == OP_PASS_LO || req_op == OP_PASS_HI) begin
         ctl0.kind = KIND_PASS;
      end else if (raw == '0) begin
         ctl0.kind = KIND_ZERO;
      end else if (cur0.slope == '0 || ro_ff == '0) begin
         ctl0.kind = KIND_SAT;            // infinite ratio or no slope
      end else begin
         ctl0.kind = KIND_CURVE;
      end
   end

   logic        s0_valid_ff;
   ctl_type     s0_ctl_ff;
   curve_type   s0_cur_ff;
   logic [31:0] s0_nn_ff;
   logic [31:0] s0_dd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ctl_ff <= ctl0;
         s0_cur_ff <= cur0;
         s0_nn_ff  <= nn;
         s0_dd_ff  <= dd;
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: normalize both operands to a q1.31 mantissa
   // ------------------------------------------------------------------------
   lg_type lg1;

   always_comb begin
      lg1.pn = gsppm_msb(s0_nn_ff);
      lg1.pd = gsppm_msb(s0_dd_ff);
      lg1.mn = s0_nn_ff << (5'd31 - lg1.pn);
      lg1.md = s0_dd_ff << (5'd31 - lg1.pd);
      lg1.fn = '0;
      lg1.fd = '0;
   end

   logic      lc_valid [0:LOG_STEPS];
   ctl_type   lc_ctl   [0:LOG_STEPS];
   curve_type lc_cur   [0:LOG_STEPS];
   lg_type    lc_lg    [0:LOG_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_valid[0] <= 1'b0;
      end else if (en) begin
         lc_valid[0] <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lc_ctl[0] <= s0_ctl_ff;
         lc_cur[0] <= s0_cur_ff;
         lc_lg[0]  <= lg1;
      end
   end

   // log2 fraction chain, most significant fraction bit first
   for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
      gsppm_log_cell #(
         .BIT(LOG_STEPS - 1 - i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (lc_valid[i]),
         .in_ctl   (lc_ctl[i]),
         .in_cur   (lc_cur[i]),
         .in_lg    (lc_lg[i]),
         .out_valid(lc_valid[i+1]),
         .out_ctl  (lc_ctl[i+1]),
         .out_cur  (lc_cur[i+1]),
         .out_lg   (lc_lg[i+1])
      );
   end

   // ------------------------------------------------------------------------
   // stage 2: log2 of the ratio in q16
   // ------------------------------------------------------------------------
   lg_type             lg_end;
   logic signed [5:0]  pdiff;
   logic signed [23:0] l2;

   assign lg_end = lc_lg[LOG_STEPS];

   always_comb begin
      pdiff = $signed({1'b0, lg_end.pn}) - $signed({1'b0, lg_end.pd});
      l2    = $signed({{2{pdiff[5]}}, pdiff, 16'b0})
            + $signed({8'b0, lg_end.fn}) - $signed({8'b0, lg_end.fd});
   end

   logic               s2_valid_ff;
   ctl_type            s2_ctl_ff;
   curve_type          s2_cur_ff;
   logic signed [23:0] s2_l2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= lc_valid[LOG_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ctl_ff <= lc_ctl[LOG_STEPS];
         s2_cur_ff <= lc_cur[LOG_STEPS];
         s2_l2_ff  <= l2;
      end
   end

   // ------------------------------------------------------------------------
   // stage 3: scale log2 to log10
   // ------------------------------------------------------------------------
   logic               s3_valid_ff;
   ctl_type            s3_ctl_ff;
   curve_type          s3_cur_ff;
   logic signed [39:0] s3_l2p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ctl_ff <= s2_ctl_ff;
         s3_cur_ff <= s2_cur_ff;
         s3_l2p_ff <= 40'(s2_l2_ff) * 40'(LOG10_2_Q16);
      end
   end

   // ------------------------------------------------------------------------
   // stage 4: subtract y, split into sign and magnitude for the divider
   // ------------------------------------------------------------------------
   logic signed [23:0] l10;
   logic signed [23:0] ysh;
   logic signed [23:0] ydiff;
   logic [23:0]        ymag;
   dv_type             dv4;

   always_comb begin
      l10   = $signed(s3_l2p_ff[39:16]);           // floor by arithmetic shift
      ysh   = $signed({{4{s3_cur_ff.y[15]}}, s3_cur_ff.y, 4'b0});
      ydiff = l10 - ysh;
      ymag  = ydiff[23] ? 24'(-ydiff) : 24'(ydiff);
      dv4.rem = '0;
      dv4.dvd = {ymag[21:0], 12'b0};
      dv4.dsr = s3_cur_ff.slope[15] ? (~s3_cur_ff.slope + 16'd1) : s3_cur_ff.slope;
      dv4.neg = ydiff[23] ^ s3_cur_ff.slope[15];
   end

   logic        dc_valid [0:DIV_BITS];
   ctl_type     dc_ctl   [0:DIV_BITS];
   logic [15:0] dc_x     [0:DIV_BITS];
   dv_type      dc_dv    [0:DIV_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_valid[0] <= 1'b0;
      end else if (en) begin
         dc_valid[0] <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dc_ctl[0] <= s3_ctl_ff;
         dc_x[0]   <= s3_cur_ff.x;
         dc_dv[0]  <= dv4;
      end
   end

   // divider chain, one quotient bit per cell
   for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
      gsppm_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (dc_valid[i]),
         .in_ctl   (dc_ctl[i]),
         .in_x     (dc_x[i]),
         .in_dv    (dc_dv[i]),
         .out_valid(dc_valid[i+1]),
         .out_ctl  (dc_ctl[i+1]),
         .out_x    (dc_x[i+1]),
         .out_dv   (dc_dv[i+1])
      );
   end

   // ------------------------------------------------------------------------
   // stage 5: signed quotient plus x, the log10 of ppm in q16
   // ------------------------------------------------------------------------
   dv_type             dv_end;
   logic signed [35:0] qs;
   logic signed [35:0] xsh;
   logic [15:0]        x_end;

   assign dv_end = dc_dv[DIV_BITS];
   assign x_end  = dc_x[DIV_BITS];

   always_comb begin
      qs  = dv_end.neg ? -$signed({2'b0, dv_end.dvd}) : $signed({2'b0, dv_end.dvd});
      xsh = $signed({{16{x_end[15]}}, x_end, 4'b0});
   end

   logic               s5_valid_ff;
   ctl_type            s5_ctl_ff;
   logic signed [35:0] s5_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= dc_valid[DIV_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_ctl_ff <= dc_ctl[DIV_BITS];
         s5_t_ff   <= qs + xsh;
      end
   end

   // ------------------------------------------------------------------------
   // stage 6: scale to log2
   // ------------------------------------------------------------------------
   logic               s6_valid_ff;
   ctl_type            s6_ctl_ff;
   logic signed [53:0] s6_tp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_ctl_ff <= s5_ctl_ff;
         s6_tp_ff  <= 54'(s5_t_ff) * 54'(LOG2_10_Q16);
      end
   end

   // ------------------------------------------------------------------------
   // stage 7: integer and fraction of the exponent, range check
   // ------------------------------------------------------------------------
   logic signed [21:0] ip;
   ctl_type            ctl7;
   ex_type             ex7;

   always_comb begin
      ip      = $signed(s6_tp_ff[53:32]);
      ex7.acc = 31'h4000_0000;                   // 1.0 in q30
      ex7.f   = s6_tp_ff[31:16];
      ex7.sh  = ip[4:0] - 5'd8;                  // output is q8
      ctl7    = s6_ctl_ff;
      if (s6_ctl_ff.kind == KIND_CURVE) begin
         if (ip > 22'sd23) begin
            ctl7.kind = KIND_SAT;
         end else if (ip < -22'sd8) begin
            ctl7.kind = KIND_TINY;               // truncates to zero
         end
      end
   end

   logic    ec_valid [0:EXP_STEPS];
   ctl_type ec_ctl   [0:EXP_STEPS];
   ex_type  ec_ex    [0:EXP_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         ec_valid[0] <= 1'b0;
      end else if (en) begin
         ec_valid[0] <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ec_ctl[0] <= ctl7;
         ec_ex[0]  <= ex7;
      end
   end

   // exp2 fraction chain, largest root first
   for (genvar i = 0; i < EXP_STEPS; i++) begin : g_exp
      gsppm_exp_cell #(
         .STEP(i + 1)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (ec_valid[i]),
         .in_ctl   (ec_ctl[i]),
         .in_ex    (ec_ex[i]),
         .out_valid(ec_valid[i+1]),
         .out_ctl  (ec_ctl[i+1]),
         .out_ex   (ec_ex[i+1])
      );
   end

   // ------------------------------------------------------------------------
   // output stage: shift the mantissa into q24.8 and format the result
   // ------------------------------------------------------------------------
   ex_type      ex_end;
   ctl_type     ctl_end;
   logic [16:0] mant;
   logic [4:0]  amt;
   logic [47:0] wide;
   logic [31:0] value_in;
   logic [1:0]  status_in;

   assign ex_end  = ec_ex[EXP_STEPS];
   assign ctl_end = ec_ctl[EXP_STEPS];

   always_comb begin
      mant = ex_end.acc[30:14];
      amt  = ~ex_end.sh + 5'd1;
      if (!ex_end.sh[4]) begin
         wide = 48'(mant) << ex_end.sh[3:0];
      end else begin
         wide = 48'(mant) >> amt;
      end
      case (ctl_end.kind)
         KIND_PASS: begin
            value_in  = 32'(ctl_end.raw);
            status_in = ST_OK;
         end
         KIND_ZERO: begin
            value_in  = '0;
            status_in = ST_ZERO;
         end
         KIND_TINY: begin
            value_in  = '0;
            status_in = ST_OK;
         end
         KIND_CURVE: begin
            if (|wide[47:32]) begin
               value_in  = '1;
               status_in = ST_SAT;
            end else begin
               value_in  = wide[31:0];
               status_in = ST_OK;
            end
         end
         default: begin
            value_in  = '1;
            status_in = ST_SAT;
         end
      endcase
   end

   logic [31:0] rsp_value_ff;
   logic [1:0]  rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ec_valid[EXP_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_value_ff  <= value_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

[tb/tb_gas_sensor_ppm_conversion_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gas_sensor_ppm_conversion_unit
// self-checking bench for the gas sensor ppm conversion pipeline
// ----------------------------------------------------------------------------
// A directed table covers pass-through, zero samples, the sample extremes and
// saturation. Random samples then run under several register settings, with
// sender gaps, receiver stalls and then both in separate phases. Every result is checked
// in order against a fixed-point predictor of the log-log curve.
// ----------------------------------------------------------------------------
module tb_gas_sensor_ppm_conversion_unit;
   import gsppm_pkg::*;

   localparam int PIPE_CYCLES = 75;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
   } ppm_result_type;

   typedef struct {
      logic [11:0] raw;
      logic [1:0]  op;
      bit          typed;
      logic [31:0] value;
      logic [1:0]  status;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [11:0] req_raw_sample = '0;
   logic [1:0]  req_op = OP_PASS_LO;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_value;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = REG_RO;
   logic [15:0] csr_wdata = '0;

   // shadow copy of the register file
   logic [15:0] reg_shadow [0:6];

   ppm_result_type pending_ppm [$];
   int             error_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;

   gas_sensor_ppm_conversion_unit i_dut (.*);

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   function automatic longint floor_div16(longint a);
      if (a >= 0) return a / 65536;
      return -((-a + 65535) / 65536);
   endfunction

   // log2 in q16: msb index plus 16 fraction bits by repeated squaring
   function automatic longint log2_q16(longint unsigned v);
      int p;
      longint unsigned m;
      longint frac;
      p = 63;
      frac = 0;
      while (p > 0 && v[p] == 1'b0) p--;
      if (p >= 31) m = v >> (p - 31);
      else m = v << (31 - p);
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            frac |= longint'(1) << i;
            m >>= 1;
         end
      end
      return longint'(p) * 65536 + frac;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned exp2_frac(longint unsigned f);
      longint unsigned acc, root;
      acc = 64'd1 << 30;
      root = 64'd1 << 31;
      for (int k = 1; k <= 16; k++) begin
         root = int_sqrt(root << 30);
         if ((f >> (16 - k)) & 1) acc = (acc * root) >> 30;
      end
      return acc >> 14;
   endfunction

   function automatic ppm_result_type predict_ppm(logic [11:0] raw, logic [1:0] op);
      ppm_result_type r;
      longint x, y, slope, l2, l10, t, e, ip, f, s;
      longint unsigned num, den, m;
      r.value = 32'hFFFF_FFFF;
      r.status = ST_SAT;
      if (op == OP_PASS_LO || op == OP_PASS_HI) begin
         r.value = 32'(raw);
         r.status = ST_OK;
         return r;
      end
      if (raw == 0) begin
         r.value = 0;
         r.status = ST_ZERO;
         return r;
      end
      x = longint'($signed(reg_shadow[op == OP_LPG ? REG_LPG_X : REG_SMOKE_X]));
      y = longint'($signed(reg_shadow[op == OP_LPG ? REG_LPG_Y : REG_SMOKE_Y]));
      slope = longint'($signed(reg_shadow[op == OP_LPG ? REG_LPG_SLOPE : REG_SMOKE_SLOPE]));
      num = 10 * (4096 - longint'(raw)) * 256;
      den = longint'(raw) * longint'(reg_shadow[REG_RO]);
      if (slope == 0 || den == 0) return r;
      l2 = log2_q16(num) - log2_q16(den);
      l10 = floor_div16(l2 * LOG10_2_Q16);
      t = ((l10 - y * 16) * 4096) / slope + x * 16;
      e = floor_div16(t * LOG2_10_Q16);
      ip = floor_div16(e);
      f = e - ip * 65536;
      m = exp2_frac(longint'(f));
      s = ip - 8;
      if (s >= 16) return r;
      if (s >= 0) m <<= s;
      else if (s <= -17) m = 0;
      else m >>= -s;
      if (m > 64'hFFFF_FFFF) return r;
      r.value = m[31:0];
      r.status = ST_OK;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   // stall the output at random, sample results on the edge
   always @(posedge clock) begin
      ppm_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_ppm.size() == 0) begin
               report_mismatch("unexpected result", rsp_value, 32'h0);
            end else begin
               want = pending_ppm.pop_front();
               if (rsp_value !== want.value) report_mismatch("value", rsp_value, want.value);
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------
   task automatic send_request(logic [11:0] raw, logic [1:0] op, bit typed,
                               logic [31:0] tv, logic [1:0] ts);
      ppm_result_type want;
      // optional sender gap
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      want = predict_ppm(raw, op);
      if (typed) begin
         // hand-typed row must agree with the predictor too
         if (want.value !== tv || want.status !== ts)
            report_mismatch("table row", want.value, tv);
         want.value = tv;
         want.status = ts;
      end
      req_valid <= 1'b1;
      req_raw_sample <= raw;
      req_op <= op;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_ppm.push_back(want);
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_ppm.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // the caller drops csr_valid after the last write of a burst
   task automatic write_reg(logic [2:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      reg_shadow[idx] = data;
   endtask

   // curve requests mostly, pass-through now and then
   function automatic logic [1:0] pick_op();
      int r;
      r = $urandom_range(9);
      if (r < 4) return OP_LPG;
      if (r < 8) return OP_SMOKE;
      return r[0] ? OP_PASS_HI : OP_PASS_LO;
   endfunction

   function automatic logic [11:0] pick_raw();
      case ($urandom_range(5))
         0: return 12'($urandom_range(4095, 4000));
         1: return 12'($urandom_range(20, 1));
         default: return 12'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   stim_row_type directed [] = '{
      '{12'd0,    OP_PASS_LO, 1, 32'd0,        ST_OK},
      '{12'd4095, OP_PASS_LO, 1, 32'd4095,     ST_OK},
      '{12'hAAA,  OP_PASS_HI, 1, 32'hAAA,      ST_OK},
      '{12'h555,  OP_PASS_HI, 1, 32'h555,      ST_OK},
      '{12'd0,    OP_LPG,     1, 32'd0,        ST_ZERO},
      '{12'd0,    OP_SMOKE,   1, 32'd0,        ST_ZERO},
      '{12'd1,    OP_LPG,     1, 32'd0,        ST_OK},
      '{12'd1,    OP_SMOKE,   1, 32'd0,        ST_OK},
      '{12'd4095, OP_LPG,     0, 32'd0,        ST_OK},
      '{12'd4095, OP_SMOKE,   0, 32'd0,        ST_OK},
      '{12'd2048, OP_LPG,     0, 32'd0,        ST_OK},
      '{12'd2048, OP_SMOKE,   0, 32'd0,        ST_OK},
      '{12'd372,  OP_LPG,     0, 32'd0,        ST_OK},
      '{12'd1000, OP_SMOKE,   0, 32'd0,        ST_OK},
      '{12'd3000, OP_LPG,     0, 32'd0,        ST_OK}
   };

   // register settings per phase: ro, lpg x/y/slope, smoke x/y/slope
   logic [15:0] settings [0:3][0:6] = '{
      '{RO_RESET, LPG_X_RESET, LPG_Y_RESET, LPG_SLOPE_RESET,
        SMOKE_X_RESET, SMOKE_Y_RESET, SMOKE_SLOPE_RESET},
      '{16'd1, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000},
      '{16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 16'd4096, 16'hF000, 16'hFFFF},
      '{16'd0, 16'd2000, 16'd1000, 16'd0, 16'd6000, 16'd500, 16'hF000}
   };

   initial begin
      int idle_tab [0:3] = '{0, 50, 0, 22};
      int stall_tab [0:3] = '{0, 0, 50, 22};
      for (int i = 0; i < 7; i++) reg_shadow[i] = settings[0][i];
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at reset values
      foreach (directed[i])
         send_request(directed[i].raw, directed[i].op, directed[i].typed,
                      directed[i].value, directed[i].status);
      drain_pipe();

      // each setting runs through all idling phases
      for (int s = 0; s < 4; s++) begin
         if (s != 0) begin
            for (int r = 0; r < 7; r++) write_reg(3'(r), settings[s][r]);
            csr_valid <= 1'b0;
            @(posedge clock);
         end
         for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            for (int n = 0; n < 100; n++) begin
               send_request(pick_raw(), pick_op(), 0, '0, '0);
               // sender waits for the pipeline to empty once per phase
               if (n == 50) drain_pipe();
            end
         end
         recv_stall_pct = 0;
         drain_pipe();
      end
      // a last round with fully random values in every register
      for (int r = 0; r < 7; r++) write_reg(3'(r), 16'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
      recv_stall_pct = 22;
      send_idle_pct = 22;
      for (int n = 0; n < 100; n++) send_request(pick_raw(), pick_op(), 0, '0, '0);
      recv_stall_pct = 0;
      drain_pipe();
      repeat (PIPE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

endmodule
